/* design/gbt_pkg.sv */
// Shared constants, types, action codes and the column remap function for the glyph bitmap transform block.
package gbt_pkg;
	localparam int unsigned ROWS      = 96;
	localparam int unsigned ROW_WORDS = 3;
	localparam int unsigned ROW_BITS  = 32 * ROW_WORDS;
	localparam int unsigned ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [ROW_AW-1:0]   row_addr_t;

	typedef enum logic [3:0] {
		ACT_WRITE   = 4'd0,
		ACT_READ    = 4'd1,
		ACT_UP      = 4'd2,
		ACT_DOWN    = 4'd3,
		ACT_LEFT    = 4'd4,
		ACT_RIGHT   = 4'd5,
		ACT_MIRROR_R= 4'd6,
		ACT_MIRROR_C= 4'd7,
		ACT_HALF_H  = 4'd8,
		ACT_DOUBLE_H= 4'd9,
		ACT_HALF_W  = 4'd10,
		ACT_DOUBLE_W= 4'd11
	} action_t;

	// Column remap of one row; pixel p sits at bit ROW_BITS-1-p.
	function automatic row_t remap_cols(input logic [3:0] act, input row_t src);
		row_t d;
		int unsigned p;
		int unsigned q;
		d = src;
		for (p = 0; p < ROW_BITS; p++) begin
			case (act)
				ACT_LEFT: begin
					q = (p + 1) % ROW_BITS;
					d[ROW_BITS-1-p] = src[ROW_BITS-1-q];
				end
				ACT_RIGHT: begin
					q = (p + ROW_BITS - 1) % ROW_BITS;
					d[ROW_BITS-1-p] = src[ROW_BITS-1-q];
				end
				ACT_MIRROR_C: d[ROW_BITS-1-p] = src[p];
				ACT_HALF_W: begin
					if (p < ROW_BITS / 2)
						d[ROW_BITS-1-p] = src[ROW_BITS-1-2*p] | src[ROW_BITS-2-2*p];
					else
						d[ROW_BITS-1-p] = 1'b0;
				end
				ACT_DOUBLE_W: d[ROW_BITS-1-p] = src[ROW_BITS-1-p/2];
				default: d[ROW_BITS-1-p] = src[ROW_BITS-1-p];
			endcase
		end
		return d;
	endfunction
endpackage

/* design/gbt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gbt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

/* design/glyph_bitmap_transform.sv */
// Top level: glyph bitmap editor built around two row-wide bitmap memories.
// Word write/read and unknown actions: ST_WORD, then ST_WORD_WB, then ST_DONE loads the result.
// Column transforms: one row per cycle read-modify-write in place.
// Row transforms: copy to the scratch memory, then remap back into the bitmap.
// One action at a time; the next is taken while the result register still waits.
// After reset a clearing pass zeroes every bitmap row before any action.
module glyph_bitmap_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  action,
	input  logic [6:0]  row_index,
	input  logic [1:0]  word_select,
	input  logic [31:0] word_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic [3:0]  done_action
);
	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_WORD, ST_WORD_WB, ST_COPY, ST_REMAP, ST_DONE
	} state_t;

	localparam int unsigned WSW = (gbt_pkg::ROW_WORDS > 1) ? $clog2(gbt_pkg::ROW_WORDS) : 1;
	localparam int unsigned ROW_AW1 = gbt_pkg::ROW_AW + 1;

	state_t                 state_q;
	gbt_pkg::row_addr_t     cnt_q;
	logic                   rd_vld_q;
	gbt_pkg::row_addr_t     rd_row_q;
	logic                   rd_clr_q;
	logic [3:0]             act_q;
	logic [6:0]             row_q;
	logic [1:0]             sel_q;
	logic [31:0]            data_q;
	logic                   rng_q;
	logic [6:0]             row_counter_q;
	logic                   full_q;
	logic [31:0]            rdat_q;
	logic [3:0]             dact_q;

	logic                   bm_we, bm_re, sc_we, sc_re;
	gbt_pkg::row_addr_t     bm_wa, bm_ra, sc_wa, sc_ra;
	gbt_pkg::row_t          bm_wd, bm_rd, sc_rd;

	gbt_ram #(.WIDTH(gbt_pkg::ROW_BITS), .DEPTH(gbt_pkg::ROWS)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
		.re(bm_re), .raddr(bm_ra), .rdata(bm_rd));

	gbt_ram #(.WIDTH(gbt_pkg::ROW_BITS), .DEPTH(gbt_pkg::ROWS)) u_scratch (
		.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(bm_rd),
		.re(sc_re), .raddr(sc_ra), .rdata(sc_rd));

	logic is_row_act, is_col_act, last_cnt, res_free;
	gbt_pkg::row_addr_t src_row;
	logic               src_clr;
	logic [WSW-1:0]     wsel;
	gbt_pkg::row_t      wmask, wword;

	assign is_row_act = act_q == gbt_pkg::ACT_UP || act_q == gbt_pkg::ACT_DOWN ||
		act_q == gbt_pkg::ACT_MIRROR_R || act_q == gbt_pkg::ACT_HALF_H ||
		act_q == gbt_pkg::ACT_DOUBLE_H;
	assign is_col_act = act_q == gbt_pkg::ACT_LEFT || act_q == gbt_pkg::ACT_RIGHT ||
		act_q == gbt_pkg::ACT_MIRROR_C || act_q == gbt_pkg::ACT_HALF_W ||
		act_q == gbt_pkg::ACT_DOUBLE_W;
	assign last_cnt = cnt_q == gbt_pkg::row_addr_t'(gbt_pkg::ROWS - 1);
	assign res_free = !full_q || out_ready;
	assign in_ready = state_q == ST_IDLE;
	assign wsel     = sel_q[WSW-1:0];

	// Source row of each destination row for row transforms.
	always_comb begin
		src_clr = 1'b0;
		case (act_q)
			gbt_pkg::ACT_UP:
				src_row = last_cnt ? '0 : cnt_q + 1'b1;
			gbt_pkg::ACT_DOWN:
				src_row = (cnt_q == '0) ? gbt_pkg::row_addr_t'(gbt_pkg::ROWS - 1) : cnt_q - 1'b1;
			gbt_pkg::ACT_MIRROR_R:
				src_row = gbt_pkg::row_addr_t'(gbt_pkg::ROWS - 1) - cnt_q;
			gbt_pkg::ACT_HALF_H: begin
				src_row = gbt_pkg::row_addr_t'({cnt_q, 1'b0});
				src_clr = {1'b0, cnt_q} >= (ROW_AW1'(gbt_pkg::ROWS) + 1'b1) >> 1;
			end
			default: src_row = cnt_q >> 1;
		endcase
	end

	always_comb begin
		wmask = '0;
		wword = '0;
		wmask[gbt_pkg::ROW_BITS-1-32*wsel -: 32] = '1;
		wword[gbt_pkg::ROW_BITS-1-32*wsel -: 32] = data_q;
	end

	always_comb begin
		bm_we = 1'b0; bm_wa = cnt_q; bm_wd = '0;
		bm_re = 1'b0; bm_ra = cnt_q;
		sc_we = 1'b0; sc_wa = rd_row_q;
		sc_re = 1'b0; sc_ra = src_row;
		case (state_q)
			ST_CLEAR: bm_we = 1'b1;
			ST_WORD: begin
				bm_re = rng_q;
				bm_ra = gbt_pkg::row_addr_t'(row_q);
			end
			ST_WORD_WB: begin
				bm_we = rng_q && act_q == gbt_pkg::ACT_WRITE;
				bm_wa = gbt_pkg::row_addr_t'(row_q);
				bm_wd = (bm_rd & ~wmask) | wword;
			end
			ST_COPY: begin
				bm_re = !rd_vld_q || !last_cnt || is_col_act;
				sc_we = rd_vld_q && is_row_act;
				bm_we = rd_vld_q && is_col_act;
				bm_wa = rd_row_q;
				bm_wd = gbt_pkg::remap_cols(act_q, bm_rd);
			end
			ST_REMAP: begin
				sc_re = 1'b1;
				bm_we = rd_vld_q;
				bm_wa = rd_row_q;
				bm_wd = rd_clr_q ? '0 : sc_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			cnt_q         <= '0;
			rd_vld_q      <= 1'b0;
			rd_row_q      <= '0;
			rd_clr_q      <= 1'b0;
			act_q         <= '0;
			row_q         <= '0;
			sel_q         <= '0;
			data_q        <= '0;
			rng_q         <= 1'b0;
			row_counter_q <= '0;
			full_q        <= 1'b0;
			rdat_q        <= '0;
			dact_q        <= '0;
		end else begin
			if (state_q == ST_DONE && res_free)
				full_q <= 1'b1;
			else if (out_ready)
				full_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (last_cnt) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						act_q  <= action;
						row_q  <= row_index;
						sel_q  <= word_select;
						data_q <= word_data;
						rng_q  <= {1'b0, row_index} < 8'(gbt_pkg::ROWS) &&
							{1'b0, word_select} < 3'(gbt_pkg::ROW_WORDS);
						cnt_q    <= '0;
						rd_vld_q <= 1'b0;
						state_q  <= ST_WORD;
					end
				end
				ST_WORD: begin
					if (is_row_act || is_col_act)
						state_q <= ST_COPY;
					else
						state_q <= ST_WORD_WB;
				end
				ST_WORD_WB: begin
					if (rng_q && (act_q == gbt_pkg::ACT_WRITE || act_q == gbt_pkg::ACT_READ))
						row_counter_q <= row_q;
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					if (rd_vld_q && rd_row_q == gbt_pkg::row_addr_t'(gbt_pkg::ROWS - 1)) begin
						rd_vld_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= is_row_act ? ST_REMAP : ST_DONE;
					end else begin
						rd_vld_q <= bm_re;
						rd_row_q <= cnt_q;
						if (!last_cnt)
							cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_REMAP: begin
					if (rd_vld_q && rd_row_q == gbt_pkg::row_addr_t'(gbt_pkg::ROWS - 1)) begin
						rd_vld_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						rd_vld_q <= 1'b1;
						rd_row_q <= cnt_q;
						rd_clr_q <= src_clr;
						if (!last_cnt)
							cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					// read data of a word read stays in the RAM output register until here
					if (res_free) begin
						rdat_q  <= (rng_q && act_q == gbt_pkg::ACT_READ) ?
							bm_rd[gbt_pkg::ROW_BITS-1-32*wsel -: 32] : '0;
						dact_q  <= act_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = full_q;
	assign read_data   = rdat_q;
	assign done_action = dact_q;

	// row_counter is kept for completeness; never visible in a result.
	logic unused_rc;
	assign unused_rc = ^row_counter_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE)) else $error("accept outside idle");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_free) |=> out_valid) else $error("result lost");
	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready) else $error("accept during clear");
	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(sc_we && state_q == ST_REMAP)) else $error("scratch written in remap");
endmodule
